FILE: src/otu_pkg.sv
// Shared constants, codes and types of the order table unit.
// No dependencies; used by otu_ram, otu_core and order_table_unique_id_unit.
package otu_pkg;

   localparam int CAPACITY  = 64;
   localparam int QTY_BITS  = 32;
   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int SUM_BITS  = 38;
   localparam int ID_BITS   = 32;
   localparam int POS_BITS  = 6;
   localparam int RSP_CNT_BITS = 7;
   localparam int CMP_BITS  = CNT_BITS + POS_BITS;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUP       = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [QTY_BITS-1:0] qty;
      logic                closed;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic [ADDR_BITS-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      status_type              status;
      logic [CNT_BITS-1:0]     count;
      logic [SUM_BITS-1:0]     volume;
      logic [SUM_BITS-1:0]     outstanding;
      logic [ID_BITS-1:0]      read_id;
      logic [QTY_BITS-1:0]     read_qty;
   } result_type;

endpackage

FILE: src/order_table_unique_id_unit.sv
// Order table with unique ids: ordered add, delete with shift-down, clear, read.
// Channels: req_ (op, order_id, quantity, closed, position) and rsp_ (status,
// entry_count, total_volume, total_outstanding, read_id, read_quantity), both
// valid/stall; a request moves when valid is high and stall is low.
// Steps per request: clear and read need no scan,
//   add scans every held id through the memory read port,
//   delete of a held id scans to it, then makes one shift-down move per cycle
//   (read port, then write port); delete of an absent id scans every held id.
// Throughput: one request at a time; the scan and the shift-down go through
// the single read port of the entry memory.
// The response register frees the sequencer: a new request is taken while a
// response waits under rsp_stall; the next response then waits in the
// sequencer until the register drains.
// Reset (synchronous, active high) empties the table and zeroes both sums;
// memory contents are not cleared, entries at or above the count are unused.
// Depends on otu_pkg, otu_core and otu_ram.
module order_table_unique_id_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_quantity,
   input  logic        req_closed,
   input  logic [5:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_entry_count,
   output logic [37:0] rsp_total_volume,
   output logic [37:0] rsp_total_outstanding,
   output logic [31:0] rsp_read_id,
   output logic [31:0] rsp_read_quantity
);
   import otu_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rd_data;
   result_type  result;
   logic        done;
   logic        take;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;

   otu_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_order_id (req_order_id),
      .req_quantity (req_quantity),
      .req_closed   (req_closed),
      .req_position (req_position),
      .done         (done),
      .take         (take),
      .result       (result),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data)
   );

   otu_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign take = done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_entry_count       = RSP_CNT_BITS'(rsp_ff.count);
   assign rsp_total_volume      = rsp_ff.volume;
   assign rsp_total_outstanding = rsp_ff.outstanding;
   assign rsp_read_id           = rsp_ff.read_id;
   assign rsp_read_quantity     = 32'(rsp_ff.read_qty);

endmodule

FILE: src/otu_ram.sv
// Entry memory of the order table: one write port, one registered read port.
// Depends on otu_pkg.
module otu_ram (
   input  logic                clock,
   input  otu_pkg::mem_req_type mem_req,
   output otu_pkg::entry_type  rd_data
);
   import otu_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/otu_core.sv
// Sequencer of the order table: id scan, shift-down on delete, read, clear and sums.
// Depends on otu_pkg; drives otu_ram through a request struct.
module otu_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [31:0]          req_order_id,
   input  logic [31:0]          req_quantity,
   input  logic                 req_closed,
   input  logic [5:0]           req_position,
   output logic                 done,
   input  logic                 take,
   output otu_pkg::result_type  result,
   output otu_pkg::mem_req_type mem_req,
   input  otu_pkg::entry_type   mem_rd_data
);
   import otu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_READ,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [QTY_BITS-1:0]  qty_ff, qty_in;
   logic                 closed_ff, closed_in;
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [SUM_BITS-1:0]  vol_ff, vol_in;
   logic [SUM_BITS-1:0]  out_ff, out_in;
   status_type           status_ff, status_in;
   logic [ID_BITS-1:0]   rid_ff, rid_in;
   logic [QTY_BITS-1:0]  rqty_ff, rqty_in;

   logic                 match;
   logic                 scan_end;
   logic                 pos_fits;
   logic [ADDR_BITS-1:0] scan_addr;
   logic [ADDR_BITS-1:0] pos_addr;
   logic [SUM_BITS-1:0]  rd_qty_ext;
   logic [SUM_BITS-1:0]  add_qty_ext;

   assign match       = pend_ff && (mem_rd_data.id == id_ff);
   assign scan_end    = (scan_ff >= count_ff);
   assign scan_addr   = ADDR_BITS'(scan_ff);
   assign pos_fits    = (CMP_BITS'(req_position) < CMP_BITS'(count_ff));
   assign pos_addr    = ADDR_BITS'(CMP_BITS'(req_position));
   assign rd_qty_ext  = SUM_BITS'(mem_rd_data.qty);
   assign add_qty_ext = SUM_BITS'(qty_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      qty_in       = qty_ff;
      closed_in    = closed_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      count_in     = count_ff;
      vol_in       = vol_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      rid_in       = rid_ff;
      rqty_in      = rqty_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ADDR_BITS'(count_ff);
      mem_req.wr_data = '{id: id_ff, qty: qty_ff, closed: closed_ff};
      mem_req.rd_addr = (state_ff == S_IDLE) ? pos_addr : scan_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_op);
               id_in     = req_order_id;
               qty_in    = QTY_BITS'(req_quantity);
               closed_in = req_closed;
               scan_in   = '0;
               pend_in   = 1'b0;
               status_in = ST_OK;
               rid_in    = '0;
               rqty_in   = '0;
               unique case (op_type'(req_op))
                  OP_ADD, OP_DELETE: state_in = S_SCAN;
                  OP_CLEAR: begin
                     count_in = '0;
                     vol_in   = '0;
                     out_in   = '0;
                     state_in = S_DONE;
                  end
                  OP_READ: begin
                     if (pos_fits) begin
                        state_in = S_READ;
                     end else begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (match) begin
               pend_in = 1'b0;
               if (op_ff == OP_ADD) begin
                  status_in = ST_DUP;
                  state_in  = S_DONE;
               end else begin
                  vol_in = vol_ff - rd_qty_ext;
                  if (!mem_rd_data.closed) begin
                     out_in = out_ff - rd_qty_ext;
                  end
                  state_in = S_SHIFT;
               end
            end else if (scan_end) begin
               pend_in  = 1'b0;
               state_in = S_DONE;
               if (op_ff == OP_ADD) begin
                  if (count_ff == CNT_BITS'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     count_in = count_ff + 1'b1;
                     vol_in   = vol_ff + add_qty_ext;
                     if (!closed_ff) begin
                        out_in = out_ff + add_qty_ext;
                     end
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end else begin
               pend_addr_in = scan_addr;
               scan_in      = scan_ff + 1'b1;
               pend_in      = 1'b1;
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff - 1'b1;
               mem_req.wr_data = mem_rd_data;
            end
            if (scan_end) begin
               pend_in  = 1'b0;
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               pend_addr_in = scan_addr;
               scan_in      = scan_ff + 1'b1;
               pend_in      = 1'b1;
            end
         end
         S_READ: begin
            rid_in   = mem_rd_data.id;
            rqty_in  = mem_rd_data.qty;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         vol_ff   <= '0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         vol_ff   <= vol_in;
         out_ff   <= out_in;
      end
      op_ff        <= op_in;
      id_ff        <= id_in;
      qty_ff       <= qty_in;
      closed_ff    <= closed_in;
      scan_ff      <= scan_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      rid_ff       <= rid_in;
      rqty_ff      <= rqty_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE);
   assign result    = '{status: status_ff, count: count_ff, volume: vol_ff,
                        outstanding: out_ff, read_id: rid_ff, read_qty: rqty_ff};

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |->
         (count_ff == '0) || (count_ff == $past(count_ff) + 1'b1) ||
         (count_ff + 1'b1 == $past(count_ff)))
      else $error("entry count moved by more than one");

   a_empty_sums: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (vol_ff == '0) && (out_ff == '0))
      else $error("empty table with nonzero sums");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      done && !take |=> done && $stable(status_ff) && $stable(count_ff))
      else $error("finished result changed before it was taken");
`endif

endmodule
